@@ hdl/point_in_polygon_crossing_test_macros.svh @@
// Assertion macros used by the checker of the point-in-polygon block.
`ifndef POINT_IN_POLYGON_CROSSING_TEST_MACROS_SVH
`define POINT_IN_POLYGON_CROSSING_TEST_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define PIPCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define PIPCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/pipct_pkg.sv @@
// Types, widths and edge arithmetic helpers for the point-in-polygon block.
package pipct_pkg;

  // Coordinate width and the widths that grow from it.
  localparam int CW = 32;
  localparam int DW = CW + 1;       // difference of two coordinates
  localparam int PW = 2 * DW;       // product of two differences
  localparam int XW = PW + 1;       // difference of two products
  localparam int NEDGE = 2;         // edges evaluated per beat
  localparam int IN_TDATA_W = ((2 * CW + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_PAD_W = OUT_TDATA_W - 2;
  localparam int CFG_IDX_W = 1;

  // Edge lanes: the edge from the previous vertex, and the closing edge.
  localparam int LANE_OPEN = 0;
  localparam int LANE_CLOSE = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUERY_X = 1'b0,
    CFG_QUERY_Y = 1'b1
  } cfg_idx_t;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [XW-1:0] cross_t;

  // Operands of one edge after the input stage.
  typedef struct packed {
    diff_t dx_ab;
    diff_t dy_ap;
    diff_t dx_ap;
    diff_t dy_ab;
    logic  box_in;
    logic  y_in;
    logic  swap;
    logic  en;
  } edge_op_t;

  // Products of one edge after the multiply stage.
  typedef struct packed {
    prod_t pa;
    prod_t pb;
    logic  box_in;
    logic  y_in;
    logic  swap;
    logic  en;
  } edge_prod_t;

  // Outcome of one edge.
  typedef struct packed {
    logic hit;
    logic toggle;
  } edge_res_t;

  // Differences and compares for the edge a -> b against point p.
  function automatic edge_op_t edge_setup(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                          coord_t px, coord_t py, logic en);
    edge_op_t o;
    o.dx_ab  = DW'(bx) - DW'(ax);
    o.dy_ap  = DW'(py) - DW'(ay);
    o.dx_ap  = DW'(px) - DW'(ax);
    o.dy_ab  = DW'(by) - DW'(ay);
    o.box_in = ((ax <= px && px <= bx) || (bx <= px && px <= ax)) &&
               ((ay <= py && py <= by) || (by <= py && py <= ay));
    // Half-open y range of the edge ordered by y: lower <= py < upper.
    o.y_in   = (ay <= py && py < by) || (by <= py && py < ay);
    o.swap   = ay > by;
    o.en     = en;
    return o;
  endfunction

  // Sign of the cross product decides boundary hit and parity toggle.
  function automatic edge_res_t edge_finish(edge_prod_t p);
    edge_res_t r;
    cross_t    cr;
    logic      zero;
    logic      neg;
    cr   = XW'(p.pa) - XW'(p.pb);
    zero = (cr == '0);
    neg  = cr[XW-1];
    r.hit    = p.en && zero && p.box_in;
    // Swapped endpoints flip the orientation, so a negative product counts.
    r.toggle = p.en && p.y_in && (p.swap ? neg : (!neg && !zero));
    return r;
  endfunction

endpackage

@@ hdl/point_in_polygon_crossing_test.sv @@
// Point-in-polygon crossing test over a stream of polygon vertices.
//
//  channel  | direction | tdata / tuser                              | tlast
//  ---------+-----------+--------------------------------------------+-------------
//  in_      | slave     | vertex_x [CW-1:0], vertex_y [2CW-1:CW]      | last_vertex
//  out_     | master    | inside_res [0], on_boundary [1]             | none
//  cfg_     | write     | index 0 query_x, index 1 query_y            | none
//
// One vertex beat is taken per cycle while no stalled result blocks the input;
// a result leaves through the input stage, multiply stage, cross-product stage
// and output register. Each edge uses two 33x33 multipliers, one pass each.
// Reset (rst_n low, synchronous) empties the pipeline and arms for a new polygon.
// A stalled result holds a last-vertex beat in the cross-product stage, and the
// beats behind it wait; beats without last_vertex pass that stage regardless.
module point_in_polygon_crossing_test (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pipct_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [pipct_pkg::CW-1:0]            cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Bits from low: vertex_x, vertex_y.
  input  logic [pipct_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Bits from low: inside_res, on_boundary, zero padding.
  output logic [pipct_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int CW = pipct_pkg::CW;
  localparam int NEDGE = pipct_pkg::NEDGE;

  // Query point.
  pipct_pkg::coord_t qx_r, qy_r;

  // Polygon walk state.
  pipct_pkg::coord_t first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic              await_r;

  // Pipeline stages.
  logic                  s1_v_r, s1_last_r, s1_first_r;
  pipct_pkg::edge_op_t   s1_op_r   [NEDGE];
  logic                  s2_v_r, s2_last_r, s2_first_r;
  pipct_pkg::edge_prod_t s2_prod_r [NEDGE];
  logic                  s3_v_r, s3_last_r, s3_first_r;
  pipct_pkg::edge_res_t  s3_res_r  [NEDGE];

  // Accumulators and result register.
  logic par_r, bnd_r, par_nxt, bnd_nxt;
  logic out_v_r, out_inside_r, out_bnd_r;

  pipct_pkg::coord_t   in_x, in_y, cls_x, cls_y;
  pipct_pkg::edge_op_t op   [NEDGE];
  pipct_pkg::edge_prod_t prod [NEDGE];
  pipct_pkg::edge_res_t  res  [NEDGE];
  logic in_fire, out_free, s1_rdy, s2_rdy, s3_rdy, s3_fire;

  assign in_x = in_tdata[CW-1:0];
  assign in_y = in_tdata[2*CW-1:CW];

  // Stage readiness; a bubble in any stage lets the stages before it move.
  assign out_free  = !out_v_r || out_tready;
  assign s3_rdy    = !s3_v_r || !s3_last_r || out_free;
  assign s3_fire   = s3_v_r && s3_rdy;
  assign s2_rdy    = !s2_v_r || s3_rdy;
  assign s1_rdy    = !s1_v_r || s2_rdy;
  assign in_tready = s1_rdy;
  assign in_fire   = in_tvalid && s1_rdy;

  // The closing edge of a single-vertex polygon runs back onto the same vertex.
  assign cls_x = await_r ? in_x : first_x_r;
  assign cls_y = await_r ? in_y : first_y_r;

  // Edge operands from the incoming vertex.
  always_comb begin
    op[pipct_pkg::LANE_OPEN]  = pipct_pkg::edge_setup(prev_x_r, prev_y_r, in_x, in_y,
                                                      qx_r, qy_r, !await_r);
    op[pipct_pkg::LANE_CLOSE] = pipct_pkg::edge_setup(in_x, in_y, cls_x, cls_y,
                                                      qx_r, qy_r, in_tlast);
  end

  // Two products per edge.
  always_comb begin
    for (int i = 0; i < NEDGE; i++) begin
      prod[i].pa     = pipct_pkg::PW'(s1_op_r[i].dx_ab) * pipct_pkg::PW'(s1_op_r[i].dy_ap);
      prod[i].pb     = pipct_pkg::PW'(s1_op_r[i].dx_ap) * pipct_pkg::PW'(s1_op_r[i].dy_ab);
      prod[i].box_in = s1_op_r[i].box_in;
      prod[i].y_in   = s1_op_r[i].y_in;
      prod[i].swap   = s1_op_r[i].swap;
      prod[i].en     = s1_op_r[i].en;
    end
  end

  // Cross product sign per edge.
  always_comb begin
    for (int i = 0; i < NEDGE; i++) begin
      res[i] = pipct_pkg::edge_finish(s2_prod_r[i]);
    end
  end

  // Parity and boundary folding; the first vertex of a polygon starts fresh.
  always_comb begin
    par_nxt = (s3_first_r ? 1'b0 : par_r) ^ s3_res_r[pipct_pkg::LANE_OPEN].toggle
              ^ s3_res_r[pipct_pkg::LANE_CLOSE].toggle;
    bnd_nxt = (s3_first_r ? 1'b0 : bnd_r) | s3_res_r[pipct_pkg::LANE_OPEN].hit
              | s3_res_r[pipct_pkg::LANE_CLOSE].hit;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qx_r <= '0;
      qy_r <= '0;
    end else if (cfg_we) begin
      case (pipct_pkg::cfg_idx_t'(cfg_addr))
        pipct_pkg::CFG_QUERY_X: qx_r <= cfg_wdata[CW-1:0];
        pipct_pkg::CFG_QUERY_Y: qy_r <= cfg_wdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // Vertex walk: remember the first and the previous vertex.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_r <= 1'b1;
    end else if (in_fire) begin
      await_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      prev_x_r <= in_x;
      prev_y_r <= in_y;
      if (await_r) begin
        first_x_r <= in_x;
        first_y_r <= in_y;
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_tvalid;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (s3_rdy) s3_v_r <= s2_v_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_last_r  <= in_tlast;
      s1_first_r <= await_r;
      s1_op_r    <= op;
    end
    if (s1_v_r && s2_rdy) begin
      s2_last_r  <= s1_last_r;
      s2_first_r <= s1_first_r;
      s2_prod_r  <= prod;
    end
    if (s2_v_r && s3_rdy) begin
      s3_last_r  <= s2_last_r;
      s3_first_r <= s2_first_r;
      s3_res_r   <= res;
    end
  end

  // Accumulators and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      par_r   <= 1'b0;
      bnd_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s3_fire) begin
        par_r <= s3_last_r ? 1'b0 : par_nxt;
        bnd_r <= s3_last_r ? 1'b0 : bnd_nxt;
      end
      if (s3_fire && s3_last_r) begin
        out_v_r      <= 1'b1;
        out_inside_r <= par_nxt | bnd_nxt;
        out_bnd_r    <= bnd_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {pipct_pkg::OUT_PAD_W'(0), out_bnd_r, out_inside_r};

endmodule

@@ hdl/pipct_checker.sv @@
// Port-level checker for the point-in-polygon block, bound to the top level.
`include "point_in_polygon_crossing_test_macros.svh"

module pipct_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              in_tlast,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [pipct_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // Last-vertex beats taken whose result has not left yet.
  logic [2:0] pend_r;
  logic       last_fire, out_fire;

  assign last_fire = in_tvalid && in_tready && in_tlast;
  assign out_fire  = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (last_fire && !out_fire) begin
      pend_r <= pend_r + 3'd1;
    end else if (out_fire && !last_fire) begin
      pend_r <= pend_r - 3'd1;
    end
  end

  `PIPCT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped")
  `PIPCT_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "payload moved")
  `PIPCT_ASSERT_NOW(a_bnd_inside, out_tvalid, !out_tdata[1] || out_tdata[0], "boundary not inside")
  `PIPCT_ASSERT_NOW(a_no_orphan, out_fire, pend_r != 3'd0, "result without a last vertex")

endmodule

bind point_in_polygon_crossing_test pipct_checker u_pipct_checker (.*);

@@ test/tb_top.sv @@
// Self-checking testbench for the streaming point-in-polygon crossing test.
`timescale 1ns / 100ps

module tb_top;
  import pipct_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_VERTICES = 265;
  localparam int REQUERY_EVERY = 15;
  localparam coord_t C_MIN = 32'sh8000_0000;
  localparam coord_t C_MAX = 32'sh7fff_ffff;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   is_last;
  } vertex_t;

  typedef struct packed {
    logic in_poly;
    logic touched;
  } verdict_t;

  // Block ports.
  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr = '0;
  logic [CW-1:0]          cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // Bits from low: vertex_x, vertex_y.
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // Bits from low: inside_res, on_boundary, zero padding.
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Vertices waiting to be driven and verdicts waiting to arrive.
  vertex_t  vertex_q[$];
  verdict_t verdict_q[$];
  vertex_t  drive_beat;

  // Shadow of the block: query registers and the open polygon.
  coord_t qx = '0;
  coord_t qy = '0;
  coord_t first_x = '0;
  coord_t first_y = '0;
  coord_t prev_x = '0;
  coord_t prev_y = '0;
  logic   parity = 1'b0;
  logic   touched = 1'b0;
  logic   poly_open = 1'b0;

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int beats_issued = 0;
  int beats_taken = 0;
  int n_results = 0;
  int n_inside = 0;
  int n_touched = 0;
  int n_writes = 0;
  int errors = 0;

  point_in_polygon_crossing_test dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sign of (b - a) x (c - a), computed wide enough to be exact.
  function automatic int cross_sign(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                    coord_t cx, coord_t cy);
    logic signed [67:0] dxb, dyb, dxc, dyc, crs;
    dxb = bx;
    dxb = dxb - ax;
    dyb = by;
    dyb = dyb - ay;
    dxc = cx;
    dxc = dxc - ax;
    dyc = cy;
    dyc = dyc - ay;
    crs = dxb * dyc - dxc * dyb;
    if (crs < 0) return -1;
    if (crs == 0) return 0;
    return 1;
  endfunction

  function automatic logic between(coord_t p, coord_t a, coord_t b);
    return (a <= b) ? (a <= p && p <= b) : (b <= p && p <= a);
  endfunction

  // Boundary test and ray crossing for one edge against the query point.
  task automatic score_edge(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    coord_t lx, ly, hx, hy;
    if (cross_sign(ax, ay, bx, by, qx, qy) == 0 && between(qx, ax, bx) &&
        between(qy, ay, by))
      touched = 1'b1;
    if (ay > by) begin
      lx = bx; ly = by; hx = ax; hy = ay;
    end else begin
      lx = ax; ly = ay; hx = bx; hy = by;
    end
    if (ly <= qy && qy < hy && cross_sign(lx, ly, hx, hy, qx, qy) > 0)
      parity = ~parity;
  endtask

  // Advance the shadow by one vertex; a closing vertex yields a verdict.
  task automatic classify_vertex(coord_t vx, coord_t vy, logic is_last);
    verdict_t v;
    if (!poly_open) begin
      first_x = vx;
      first_y = vy;
      parity = 1'b0;
      touched = 1'b0;
      poly_open = 1'b1;
    end else begin
      score_edge(prev_x, prev_y, vx, vy);
    end
    prev_x = vx;
    prev_y = vy;
    if (is_last) begin
      score_edge(vx, vy, first_x, first_y);
      v.in_poly = touched | parity;
      v.touched = touched;
      verdict_q.push_back(v);
      parity = 1'b0;
      touched = 1'b0;
      poly_open = 1'b0;
    end
  endtask

  // Vertex side: take accepted beats into the shadow.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      classify_vertex(coord_t'(in_tdata[CW-1:0]), coord_t'(in_tdata[2*CW-1:CW]), in_tlast);
      beats_taken++;
    end
  end

  // Vertex driver: hold a beat until taken, then maybe idle.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || beats_taken == beats_issued) begin
      if (vertex_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
        drive_beat = vertex_q.pop_front();
        in_tdata <= {drive_beat.y, drive_beat.x};
        in_tlast <= drive_beat.is_last;
        in_tvalid <= 1'b1;
        beats_issued++;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side: random backpressure.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // Result monitor: compare each beat with the oldest verdict.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      n_inside += out_tdata[0];
      n_touched += out_tdata[1];
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result beat, got inside=%0b boundary=%0b",
                 $time, out_tdata[0], out_tdata[1]);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (out_tdata[0] !== want.in_poly) begin
          $display("%0t: inside_res expected %0b got %0b", $time, want.in_poly, out_tdata[0]);
          errors++;
        end
        if (out_tdata[1] !== want.touched) begin
          $display("%0t: on_boundary expected %0b got %0b", $time, want.touched,
                   out_tdata[1]);
          errors++;
        end
      end
    end
  end

  task automatic push_vertex(coord_t x, coord_t y, logic is_last);
    vertex_t v;
    v.x = x;
    v.y = y;
    v.is_last = is_last;
    vertex_q.push_back(v);
  endtask

  // Stop sending until every verdict is back and the pipeline is empty.
  task automatic settle();
    while (vertex_q.size() != 0 || beats_taken != beats_issued) @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, coord_t val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    if (idx == CFG_QUERY_X) qx = val;
    else qy = val;
    n_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic coord_t extreme_value();
    case ($urandom_range(0, 4))
      0: return C_MIN;
      1: return C_MAX;
      2: return coord_t'(0);
      3: return coord_t'(-1);
      default: return coord_t'(1);
    endcase
  endfunction

  // Mostly near the query point so that edges touch it and rays cross.
  function automatic coord_t pick_coord(coord_t center);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return center + coord_t'($urandom_range(0, 8)) - 4;
      6: return extreme_value();
      default: return coord_t'($urandom());
    endcase
  endfunction

  function automatic coord_t query_value();
    case ($urandom_range(0, 3))
      0: return coord_t'($urandom_range(0, 40)) - 20;
      1: return extreme_value();
      default: return coord_t'($urandom());
    endcase
  endfunction

  task automatic queue_polygon(int n_vert);
    for (int i = 0; i < n_vert; i++)
      push_vertex(pick_coord(qx), pick_coord(qy), i == n_vert - 1);
  endtask

  // Stimulus: directed polygons, then three random phases of idling.
  initial begin
    int queued;
    int polys;
    int n_vert;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Query at the origin from reset: single vertex on it and off it,
    // a two-vertex polygon through it, a triangle and a full-range square.
    push_vertex(0, 0, 1'b1);
    push_vertex(5, -3, 1'b1);
    push_vertex(-4, 0, 1'b0);
    push_vertex(4, 0, 1'b1);
    push_vertex(-10, -10, 1'b0);
    push_vertex(10, -10, 1'b0);
    push_vertex(0, 10, 1'b1);
    push_vertex(C_MIN, C_MIN, 1'b0);
    push_vertex(C_MAX, C_MIN, 1'b0);
    push_vertex(C_MAX, C_MAX, 1'b0);
    push_vertex(C_MIN, C_MAX, 1'b1);
    settle();

    // Query on the top right corner of the full-range square.
    write_reg(CFG_QUERY_X, C_MAX);
    write_reg(CFG_QUERY_Y, C_MAX);
    push_vertex(C_MIN, C_MIN, 1'b0);
    push_vertex(C_MAX, C_MIN, 1'b0);
    push_vertex(C_MAX, C_MAX, 1'b0);
    push_vertex(C_MIN, C_MAX, 1'b1);
    settle();

    // Query at the most negative corner, outside a large triangle.
    write_reg(CFG_QUERY_X, C_MIN);
    write_reg(CFG_QUERY_Y, C_MIN);
    push_vertex(C_MAX, C_MAX, 1'b0);
    push_vertex(C_MIN, C_MAX, 1'b0);
    push_vertex(C_MAX, C_MIN, 1'b1);
    settle();

    // Query moved while a polygon is still open.
    write_reg(CFG_QUERY_X, 0);
    write_reg(CFG_QUERY_Y, 0);
    push_vertex(-10, -10, 1'b0);
    push_vertex(10, -10, 1'b0);
    settle();
    write_reg(CFG_QUERY_X, 3);
    push_vertex(0, 10, 1'b1);
    settle();

    for (int phase = 0; phase < 3; phase++) begin
      snd_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 86 : 0;
      rcv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 15 : 0;
      write_reg(CFG_QUERY_X, query_value());
      write_reg(CFG_QUERY_Y, query_value());
      queued = 0;
      polys = 0;
      while (queued < PHASE_VERTICES) begin
        n_vert = ($urandom_range(0, 9) < 7) ? $urandom_range(3, 6) : $urandom_range(1, 12);
        if (polys == 5) begin
          // Change one query coordinate between edges of the same polygon.
          queue_polygon(0);
          push_vertex(pick_coord(qx), pick_coord(qy), 1'b0);
          push_vertex(pick_coord(qx), pick_coord(qy), 1'b0);
          settle();
          if ($urandom_range(0, 1) != 0) write_reg(CFG_QUERY_X, query_value());
          else write_reg(CFG_QUERY_Y, query_value());
          queued += 2;
          n_vert = 1;
        end
        queue_polygon(n_vert);
        queued += n_vert;
        polys++;
        if (polys % REQUERY_EVERY == 0) begin
          settle();
          write_reg(CFG_QUERY_X, query_value());
          write_reg(CFG_QUERY_Y, query_value());
        end
      end
      settle();
    end

    $display("Ran %0d vertices into %0d polygon verdicts over %0d register writes.",
             beats_taken, n_results, n_writes);
    $display("Verdicts: %0d inside, %0d with the point on an edge.", n_inside, n_touched);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/pipct_pkg.sv
hdl/point_in_polygon_crossing_test.sv
hdl/pipct_checker.sv
test/tb_top.sv
